[rtl/tbpd_pkg.sv]
`default_nettype none
package tbpd_pkg;

  localparam int CordicStepsDef = 16;
  localparam int DriveLimitDef  = 126;

  localparam int SampleW    = 16;
  localparam int GainW      = 16;
  localparam int RateScaleW = 24;
  localparam int AngleW     = 18;
  localparam int DutyW      = 7;
  localparam int CfgAddrW   = 3;
  localparam int CfgDataW   = 24;

  localparam int AtanLen = 24;
  localparam int AtanIdxW = 5;
  localparam int AtanW   = 22;
  localparam int CordW   = 27;
  localparam int TiltW   = 20;
  localparam int RateW   = 24;
  localparam int PredW   = 25;
  localparam int OperW   = 25;
  localparam int MacW    = 50;

  localparam logic [GainW-1:0]      PropGainRst     = 16'd2560;
  localparam logic [GainW-1:0]      DerivGainRst    = 16'd256;
  localparam logic [GainW-1:0]      BlendWeightRst  = 16'd64225;
  localparam logic [GainW-1:0]      SamplePeriodRst = 16'd655;
  localparam logic [RateScaleW-1:0] RateScaleRst    = 24'd125446;

  // 180 degrees in Q16
  localparam logic signed [CordW-1:0] HalfTurn = 27'sd11796480;

  typedef enum logic [CfgAddrW-1:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_DERIV_GAIN    = 3'd1,
    REG_BLEND_WEIGHT  = 3'd2,
    REG_SAMPLE_PERIOD = 3'd3,
    REG_RATE_SCALE    = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_RATE,
    ST_WAIT_RATE,
    ST_GET_RATE,
    ST_MUL_PRED,
    ST_WAIT_PRED,
    ST_GET_PRED,
    ST_WAIT_TILT,
    ST_MUL_MIX1,
    ST_MUL_MIX2,
    ST_WAIT_MIX,
    ST_GET_MIX,
    ST_MUL_DRV1,
    ST_MUL_DRV2,
    ST_WAIT_DRV,
    ST_GET_DRV
  } seq_state_t;

  typedef struct packed {
    logic                    valid;
    logic                    clr;
    logic signed [OperW-1:0] a;
    logic signed [OperW-1:0] b;
  } mac_cmd_t;

  // atan(2^-i) in degrees, Q16
  function automatic logic [AtanW-1:0] atan_deg(input logic [AtanIdxW-1:0] idx);
    logic [AtanW-1:0] v;
    case (idx)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[rtl/tbpd_in_if.sv]
`default_nettype none
interface tbpd_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [tbpd_pkg::SampleW-1:0]    accel_x;
  logic signed [tbpd_pkg::SampleW-1:0]    accel_y;
  logic signed [tbpd_pkg::SampleW-1:0]    gyro_rate_raw;

  modport source (output valid, output accel_x, output accel_y, output gyro_rate_raw,
                  input ready);
  modport sink (input valid, input accel_x, input accel_y, input gyro_rate_raw,
                output ready);
endinterface
`default_nettype wire

[rtl/tbpd_out_if.sv]
`default_nettype none
interface tbpd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [tbpd_pkg::DutyW-1:0]           duty;
  logic                                 forward;
  logic signed [tbpd_pkg::AngleW-1:0]   filtered_angle;

  modport source (output valid, output duty, output forward, output filtered_angle,
                  input ready);
  modport sink (input valid, input duty, input forward, input filtered_angle,
                output ready);
endinterface
`default_nettype wire

[rtl/tbpd_cordic.sv]
`default_nettype none
module tbpd_cordic #(
  parameter int STEPS = tbpd_pkg::CordicStepsDef
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  input  wire logic signed [tbpd_pkg::SampleW-1:0]  ax,
  input  wire logic signed [tbpd_pkg::SampleW-1:0]  ay,
  output logic                                      done,
  output logic signed [tbpd_pkg::TiltW-1:0]         tilt
);

  localparam int Iters = (STEPS > tbpd_pkg::AtanLen) ? tbpd_pkg::AtanLen : STEPS;
  localparam int CW    = tbpd_pkg::CordW;
  localparam logic [tbpd_pkg::AtanIdxW-1:0] LastIdx = tbpd_pkg::AtanIdxW'(Iters - 1);

  logic signed [CW-1:0] x_r, y_r, z_r;
  logic signed [CW-1:0] x_nxt, y_nxt, z_nxt;
  logic                 zero_r;
  logic [tbpd_pkg::AtanIdxW-1:0] cnt_r;
  logic                 busy_r, done_r;

  logic signed [CW-1:0] ax_ext, ay_ext, xs, ys, at, tz, tz_sh;

  assign ax_ext = CW'(ax) <<< 8;
  assign ay_ext = CW'(ay) <<< 8;
  assign xs     = x_r >>> cnt_r;
  assign ys     = y_r >>> cnt_r;
  assign at     = $signed(CW'(tbpd_pkg::atan_deg(cnt_r)));

  always_comb begin
    if (start) begin
      if (ax < 0) begin
        x_nxt = -ax_ext;
        y_nxt = -ay_ext;
        z_nxt = (ay >= 0) ? tbpd_pkg::HalfTurn : -tbpd_pkg::HalfTurn;
      end else begin
        x_nxt = ax_ext;
        y_nxt = ay_ext;
        z_nxt = '0;
      end
    end else if (y_r > 0) begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + at;
    end else begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == LastIdx) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start || busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
    if (start) begin
      zero_r <= (ax == 0) && (ay == 0);
    end
  end

  // negate, round half up to Q8
  assign tz    = 27'sd128 - z_r;
  assign tz_sh = tz >>> 8;
  assign tilt  = zero_r ? '0 : tbpd_pkg::TiltW'(tz_sh);
  assign done  = done_r;

endmodule
`default_nettype wire

[rtl/tbpd_mac.sv]
`default_nettype none
module tbpd_mac (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire tbpd_pkg::mac_cmd_t                cmd,
  output logic signed [tbpd_pkg::MacW-1:0]       acc
);

  logic signed [tbpd_pkg::MacW-1:0] prod_r, acc_r;
  logic                             pend_r, clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid) begin
      prod_r <= cmd.a * cmd.b;
      clr_r  <= cmd.clr;
    end
    // accumulate in the cycle after the product lands
    if (pend_r) begin
      acc_r <= clr_r ? prod_r : acc_r + prod_r;
    end
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

[rtl/tilt_balance_pd_motor_drive_core.sv]
`default_nettype none
// An input beat is accepted only while the sequencer is idle, so the next item waits until the
// previous result is loaded into the output register; the tilt comes from an iterative CORDIC
// vectoring unit, and the six products share one multiply-accumulate unit.
// A finished result waits in the output register while the next item is accepted;
// a result still held there stalls the sequencer before the next output load.
// Reset (rst_n, synchronous) restores register defaults and clears the stored angle.
module tilt_balance_pd_motor_drive_core #(
  parameter int CORDIC_STEPS = tbpd_pkg::CordicStepsDef,
  parameter int DRIVE_LIMIT  = tbpd_pkg::DriveLimitDef
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  tbpd_in_if.sink                                in_bus,
  tbpd_out_if.source                             out_bus,
  input  wire logic                              cfg_we,
  input  wire logic [tbpd_pkg::CfgAddrW-1:0]     cfg_addr,
  input  wire logic [tbpd_pkg::CfgDataW-1:0]     cfg_wdata
);

  localparam int GW = tbpd_pkg::GainW;
  localparam int OW = tbpd_pkg::OperW;
  localparam int MW = tbpd_pkg::MacW;
  localparam int QW = MW - 16;
  localparam logic signed [QW-1:0] AngMax   = QW'(131071);
  localparam logic signed [QW-1:0] AngMin   = -QW'(131072);
  localparam logic signed [QW-1:0] DrvLimit = QW'(DRIVE_LIMIT);

  logic [GW-1:0]                       pg_r, dg_r, w_r, sp_r;
  logic [tbpd_pkg::RateScaleW-1:0]     rs_r;

  tbpd_pkg::seq_state_t                state_r, state_nxt;
  tbpd_pkg::mac_cmd_t                  cmd;
  logic signed [MW-1:0]                acc;
  logic                                cordic_done;
  logic signed [tbpd_pkg::TiltW-1:0]   tilt;

  logic signed [tbpd_pkg::SampleW-1:0] gz_r;
  logic signed [tbpd_pkg::RateW-1:0]   rate_r;
  logic signed [tbpd_pkg::PredW-1:0]   pred_r;
  logic signed [tbpd_pkg::AngleW-1:0]  prev_r;

  logic                                accept, load_out;
  logic                                out_valid_r, fwd_r;
  logic [tbpd_pkg::DutyW-1:0]          duty_r;
  logic signed [tbpd_pkg::AngleW-1:0]  ang_out_r;

  logic signed [MW-1:0]                mix_rnd, drv_adj;
  logic signed [QW-1:0]                ang_q, drv_q, drv_c, drv_mag;
  logic signed [tbpd_pkg::AngleW-1:0]  ang_sat;
  logic [16:0]                         w_comp;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pg_r <= tbpd_pkg::PropGainRst;
      dg_r <= tbpd_pkg::DerivGainRst;
      w_r  <= tbpd_pkg::BlendWeightRst;
      sp_r <= tbpd_pkg::SamplePeriodRst;
      rs_r <= tbpd_pkg::RateScaleRst;
    end else if (cfg_we) begin
      case (tbpd_pkg::cfg_reg_t'(cfg_addr))
        tbpd_pkg::REG_PROP_GAIN:     pg_r <= cfg_wdata[GW-1:0];
        tbpd_pkg::REG_DERIV_GAIN:    dg_r <= cfg_wdata[GW-1:0];
        tbpd_pkg::REG_BLEND_WEIGHT:  w_r  <= cfg_wdata[GW-1:0];
        tbpd_pkg::REG_SAMPLE_PERIOD: sp_r <= cfg_wdata[GW-1:0];
        tbpd_pkg::REG_RATE_SCALE:    rs_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign accept        = in_bus.valid && in_bus.ready;
  assign in_bus.ready  = (state_r == tbpd_pkg::ST_IDLE);
  assign load_out      = (state_r == tbpd_pkg::ST_GET_DRV) && (!out_valid_r || out_bus.ready);

  tbpd_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .ax    (in_bus.accel_x),
    .ay    (in_bus.accel_y),
    .done  (cordic_done),
    .tilt  (tilt)
  );

  tbpd_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .acc   (acc)
  );

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tbpd_pkg::ST_IDLE:      if (accept) state_nxt = tbpd_pkg::ST_MUL_RATE;
      tbpd_pkg::ST_MUL_RATE:  state_nxt = tbpd_pkg::ST_WAIT_RATE;
      tbpd_pkg::ST_WAIT_RATE: state_nxt = tbpd_pkg::ST_GET_RATE;
      tbpd_pkg::ST_GET_RATE:  state_nxt = tbpd_pkg::ST_MUL_PRED;
      tbpd_pkg::ST_MUL_PRED:  state_nxt = tbpd_pkg::ST_WAIT_PRED;
      tbpd_pkg::ST_WAIT_PRED: state_nxt = tbpd_pkg::ST_GET_PRED;
      tbpd_pkg::ST_GET_PRED:  state_nxt = tbpd_pkg::ST_WAIT_TILT;
      tbpd_pkg::ST_WAIT_TILT: if (cordic_done) state_nxt = tbpd_pkg::ST_MUL_MIX1;
      tbpd_pkg::ST_MUL_MIX1:  state_nxt = tbpd_pkg::ST_MUL_MIX2;
      tbpd_pkg::ST_MUL_MIX2:  state_nxt = tbpd_pkg::ST_WAIT_MIX;
      tbpd_pkg::ST_WAIT_MIX:  state_nxt = tbpd_pkg::ST_GET_MIX;
      tbpd_pkg::ST_GET_MIX:   state_nxt = tbpd_pkg::ST_MUL_DRV1;
      tbpd_pkg::ST_MUL_DRV1:  state_nxt = tbpd_pkg::ST_MUL_DRV2;
      tbpd_pkg::ST_MUL_DRV2:  state_nxt = tbpd_pkg::ST_WAIT_DRV;
      tbpd_pkg::ST_WAIT_DRV:  state_nxt = tbpd_pkg::ST_GET_DRV;
      tbpd_pkg::ST_GET_DRV:   if (load_out) state_nxt = tbpd_pkg::ST_IDLE;
      default:                state_nxt = tbpd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tbpd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign w_comp = 17'h10000 - {1'b0, w_r};

  // sequencer: multiplier operands
  always_comb begin
    cmd.valid = 1'b0;
    cmd.clr   = 1'b1;
    cmd.a     = '0;
    cmd.b     = '0;
    case (state_r)
      tbpd_pkg::ST_MUL_RATE: begin
        cmd.valid = 1'b1;
        cmd.a     = OW'(gz_r);
        cmd.b     = OW'({1'b0, rs_r});
      end
      tbpd_pkg::ST_MUL_PRED: begin
        cmd.valid = 1'b1;
        cmd.a     = OW'(rate_r);
        cmd.b     = OW'({1'b0, sp_r});
      end
      tbpd_pkg::ST_MUL_MIX1: begin
        cmd.valid = 1'b1;
        cmd.a     = pred_r;
        cmd.b     = OW'({1'b0, w_r});
      end
      tbpd_pkg::ST_MUL_MIX2: begin
        cmd.valid = 1'b1;
        cmd.clr   = 1'b0;
        cmd.a     = OW'(tilt);
        cmd.b     = OW'({1'b0, w_comp});
      end
      tbpd_pkg::ST_MUL_DRV1: begin
        cmd.valid = 1'b1;
        cmd.a     = OW'(prev_r);
        cmd.b     = OW'({1'b0, pg_r});
      end
      tbpd_pkg::ST_MUL_DRV2: begin
        cmd.valid = 1'b1;
        cmd.clr   = 1'b0;
        cmd.a     = OW'(rate_r);
        cmd.b     = OW'({1'b0, dg_r});
      end
      default: ;
    endcase
  end

  // round half up, then saturate to Q9.8
  assign mix_rnd = acc + MW'(32768);
  assign ang_q   = $signed(mix_rnd[MW-1:16]);
  always_comb begin
    if (ang_q > AngMax) begin
      ang_sat = tbpd_pkg::AngleW'(AngMax);
    end else if (ang_q < AngMin) begin
      ang_sat = tbpd_pkg::AngleW'(AngMin);
    end else begin
      ang_sat = tbpd_pkg::AngleW'(ang_q);
    end
  end

  // truncate toward zero, then clamp
  assign drv_adj = acc + (acc[MW-1] ? MW'(65535) : MW'(0));
  assign drv_q   = $signed(drv_adj[MW-1:16]);
  always_comb begin
    if (drv_q > DrvLimit) begin
      drv_c = DrvLimit;
    end else if (drv_q < -DrvLimit) begin
      drv_c = -DrvLimit;
    end else begin
      drv_c = drv_q;
    end
  end
  assign drv_mag = drv_c[QW-1] ? -drv_c : drv_c;

  // datapath holding registers
  always_ff @(posedge clk) begin
    if (accept) begin
      gz_r <= in_bus.gyro_rate_raw;
    end
    if (state_r == tbpd_pkg::ST_GET_RATE) begin
      rate_r <= acc[39:16];
    end
    if (state_r == tbpd_pkg::ST_GET_PRED) begin
      pred_r <= tbpd_pkg::PredW'(prev_r) + $signed(acc[40:16]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (state_r == tbpd_pkg::ST_GET_MIX) begin
      prev_r <= ang_sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      duty_r    <= 7'd127 - tbpd_pkg::DutyW'(drv_mag);
      fwd_r     <= !drv_c[QW-1];
      ang_out_r <= prev_r;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.duty           = duty_r;
  assign out_bus.forward        = fwd_r;
  assign out_bus.filtered_angle = ang_out_r;

endmodule
`default_nettype wire
